// ===== rtl/core/swsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor frame receiver package
// Shared constants, register indexes and types for the frame receiver.
// ----------------------------------------------------------------------------
package swsfr_pkg;

  localparam int FRAME_BITS     = 40;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int EDGE_W         = 32;
  localparam int CNT_W          = $clog2(FRAME_BITS + 1);
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int OUT_TDATA_W    = 88;

  localparam logic [15:0] HOST_MIN_RST = 16'd500;
  localparam logic [15:0] HOST_MAX_RST = 16'd30000;
  localparam logic [9:0]  ONE_THR_RST  = 10'd88;

  localparam logic [1:0] REG_HOST_MIN = 2'd0;
  localparam logic [1:0] REG_HOST_MAX = 2'd1;
  localparam logic [1:0] REG_ONE_THR  = 2'd2;

  typedef struct packed {
    logic [15:0] host_pulse_min_us;
    logic [15:0] host_pulse_max_us;
    logic [9:0]  one_bit_threshold_us;
  } cfg_t;

  typedef struct packed {
    logic               checksum_ok;
    logic [7:0]         checksum_byte;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic [39:0]        raw_frame;
  } result_t;

endpackage

// ===== rtl/core/single_wire_sensor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor frame receiver
// Decodes falling-edge timestamps of a single-wire sensor line into frames.
// ----------------------------------------------------------------------------
// Output: a result is valid on m_tvalid in the cycle after its final edge is accepted.
// Throughput: one edge request per cycle; the phase machine and shift register
// update in a single pass, and s_tready drops only while a result waits unread.
// Reset: synchronous; registers other than the held result return to their defaults and the receiver to idle.
module single_wire_sensor_frame_receiver #(
  parameter int TIME_WIDTH = swsfr_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // edge_time_us[31:0]
  input  logic [swsfr_pkg::EDGE_W-1:0]        s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // raw_frame[39:0], humidity[55:40], temperature[71:56], checksum_byte[79:72],
  // checksum_ok[80], zero fill[87:81]
  output logic [swsfr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swsfr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [swsfr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [swsfr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  swsfr_pkg::cfg_t                    cfg;
  swsfr_pkg::result_t                 result;
  swsfr_pkg::result_t                 result_q;
  logic                               in_fire;
  logic                               frame_valid;
  logic [swsfr_pkg::FRAME_BITS-1:0]   frame;

  assign in_fire = s_tvalid && s_tready;

  swsfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swsfr_rx #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_rx (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_fire      (in_fire),
    .edge_time_us (s_tdata),
    .frame_valid  (frame_valid),
    .frame        (frame)
  );

  swsfr_fmt u_fmt (
    .frame  (frame),
    .result (result)
  );

  swsfr_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (frame_valid),
    .result_in  (result),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result_out (result_q)
  );

  assign m_tdata = {7'd0, result_q.checksum_ok, result_q.checksum_byte,
                    result_q.temperature, result_q.humidity, result_q.raw_frame};

endmodule

// ===== rtl/core/swsfr_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for the pulse window and the bit threshold.
// ----------------------------------------------------------------------------
module swsfr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swsfr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [swsfr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [swsfr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output swsfr_pkg::cfg_t                     cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.host_pulse_min_us    <= swsfr_pkg::HOST_MIN_RST;
      cfg.host_pulse_max_us    <= swsfr_pkg::HOST_MAX_RST;
      cfg.one_bit_threshold_us <= swsfr_pkg::ONE_THR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        swsfr_pkg::REG_HOST_MIN: cfg.host_pulse_min_us    <= pwdata[15:0];
        swsfr_pkg::REG_HOST_MAX: cfg.host_pulse_max_us    <= pwdata[15:0];
        swsfr_pkg::REG_ONE_THR:  cfg.one_bit_threshold_us <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swsfr_pkg::REG_HOST_MIN: prdata = {16'd0, cfg.host_pulse_min_us};
      swsfr_pkg::REG_HOST_MAX: prdata = {16'd0, cfg.host_pulse_max_us};
      swsfr_pkg::REG_ONE_THR:  prdata = {22'd0, cfg.one_bit_threshold_us};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/swsfr_rx.sv =====
// ----------------------------------------------------------------------------
// Edge receiver
// Phase machine and bit shift register driven by falling-edge timestamps.
// ----------------------------------------------------------------------------
module swsfr_rx #(
  parameter int TIME_WIDTH = swsfr_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swsfr_pkg::cfg_t                      cfg,
  input  logic                                 in_fire,
  input  logic [swsfr_pkg::EDGE_W-1:0]         edge_time_us,
  output logic                                 frame_valid,
  output logic [swsfr_pkg::FRAME_BITS-1:0]     frame
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HOST = 2'd1,
    PH_ACK  = 2'd2,
    PH_BITS = 2'd3
  } phase_t;

  phase_t                             phase;
  logic [swsfr_pkg::CNT_W-1:0]        bit_count;
  logic [TIME_WIDTH-1:0]              last_edge_time;
  logic [swsfr_pkg::FRAME_BITS-1:0]   bit_shift;

  logic [TIME_WIDTH-1:0]              now;
  logic [TIME_WIDTH-1:0]              elapsed;
  logic                               in_window;
  logic                               bit_in;
  logic                               last_bit;
  logic [swsfr_pkg::CNT_W-1:0]        bit_count_next;
  logic [swsfr_pkg::FRAME_BITS-1:0]   bit_shift_next;

  assign now       = TIME_WIDTH'(edge_time_us);
  assign elapsed   = now - last_edge_time;
  assign in_window = (elapsed >= TIME_WIDTH'(cfg.host_pulse_min_us)) &&
                     (elapsed <= TIME_WIDTH'(cfg.host_pulse_max_us));
  assign bit_in    = elapsed >= TIME_WIDTH'(cfg.one_bit_threshold_us);

  assign bit_count_next = bit_count + 1'b1;
  assign bit_shift_next = {bit_shift[swsfr_pkg::FRAME_BITS-2:0], bit_in};
  assign last_bit       = bit_count == swsfr_pkg::CNT_W'(swsfr_pkg::FRAME_BITS - 1);

  assign frame_valid = in_fire && (phase == PH_BITS) && last_bit;
  assign frame       = bit_shift_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      last_edge_time <= '0;
      bit_shift      <= '0;
    end else if (in_fire) begin
      case (phase)
        PH_IDLE: begin
          last_edge_time <= now;
          phase          <= PH_HOST;
        end
        PH_HOST: begin
          phase <= in_window ? PH_ACK : PH_IDLE;
        end
        PH_ACK: begin
          phase          <= PH_BITS;
          bit_count      <= '0;
          bit_shift      <= '0;
          last_edge_time <= now;
        end
        PH_BITS: begin
          bit_shift <= bit_shift_next;
          bit_count <= bit_count_next;
          if (last_bit) begin
            phase <= PH_IDLE;
          end else begin
            last_edge_time <= now;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= swsfr_pkg::CNT_W'(swsfr_pkg::FRAME_BITS))
    else $error("bit count beyond frame length");

  a_ack_starts_frame: assert property (@(posedge clk) disable iff (rst)
    in_fire && (phase == PH_ACK) |=> (phase == PH_BITS) && (bit_count == '0))
    else $error("acknowledge edge did not start a frame");

  a_frame_to_idle: assert property (@(posedge clk) disable iff (rst)
    frame_valid |=> (phase == PH_IDLE))
    else $error("receiver not idle after frame");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(phase) && $stable(bit_count))
    else $error("receiver state moved without an edge");

endmodule

// ===== rtl/core/swsfr_fmt.sv =====
// ----------------------------------------------------------------------------
// Frame formatter
// Splits a received frame into humidity, temperature and checksum fields.
// ----------------------------------------------------------------------------
module swsfr_fmt (
  input  logic [swsfr_pkg::FRAME_BITS-1:0] frame,
  output swsfr_pkg::result_t               result
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic [7:0]  b4;
  logic [15:0] mag;
  logic [7:0]  sum;

  assign b0  = frame[39:32];
  assign b1  = frame[31:24];
  assign b2  = frame[23:16];
  assign b3  = frame[15:8];
  assign b4  = frame[7:0];
  assign mag = {1'b0, b2[6:0], b3};
  assign sum = b0 + b1 + b2 + b3;

  always_comb begin
    result.raw_frame     = frame;
    result.humidity      = {b0, b1};
    result.temperature   = b2[7] ? -$signed(mag) : $signed(mag);
    result.checksum_byte = b4;
    result.checksum_ok   = sum == b4;
  end

endmodule

// ===== rtl/core/swsfr_out.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module swsfr_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  swsfr_pkg::result_t result_in,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output swsfr_pkg::result_t result_out
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule
